/* rtl/core/mcopa_pkg.sv */
// ----------------------------------------------------------------------------
// Monte Carlo option payoff accumulator package
// Shared types, register indexes, fixed-point constants and the reciprocal
// table used by the Taylor series of the exponential.
// ----------------------------------------------------------------------------
package mcopa_pkg;

    // Number of fractional bits of the exponent and of exp(f).
    localparam int FRAC_BITS = 28;
    // ln(2) in Q.28.
    localparam logic [36:0] LN2_Q28 = 37'd186065280;
    // floor(2^48 / LN2_Q28), used to estimate the range-reduction quotient.
    localparam logic [20:0] LN2_RECIP = 21'd1512775;
    // Offset of 128*ln(2) that makes the reduced exponent non-negative.
    localparam logic [37:0] X_OFFSET = 38'd23816355840;
    // Bias of the range-reduction quotient.
    localparam logic signed [8:0] K_BIAS = 9'sd128;
    // Number of Taylor terms.
    localparam logic [3:0] EXP_TERMS = 4'd12;
    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_SPOT     = 3'd0;
    localparam logic [2:0] REG_STRIKE   = 3'd1;
    localparam logic [2:0] REG_DRIFT    = 3'd2;
    localparam logic [2:0] REG_DIFFUSE  = 3'd3;
    localparam logic [2:0] REG_DISCOUNT = 3'd4;
    localparam logic [2:0] REG_ANTI     = 3'd5;

    // One queued sample with its classification.
    typedef struct packed {
        logic signed [15:0] z;
        logic               last;
        logic               anti;
    } queue_entry_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Pricing parameters handed to the back.
    typedef struct packed {
        logic [31:0]        spot;
        logic [31:0]        strike;
        logic signed [31:0] drift;
        logic [30:0]        diffusion;
        logic [31:0]        discount;
    } price_cfg_t;

    // Sequencer states of the back.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MULX,
        ST_XSUM,
        ST_KDIV,
        ST_TMUL,
        ST_TREC,
        ST_TCOR,
        ST_SPOT,
        ST_SHIFT,
        ST_ACC,
        ST_DIVGO,
        ST_DIV,
        ST_MLO,
        ST_MHI,
        ST_MADD,
        ST_OUT
    } eng_state_t;

    // floor(2^32 / n) for the Taylor divisors 1 to 12.
    function automatic logic [32:0] recip(input logic [3:0] n);
        logic [32:0] r;
        unique case (n)
            4'd1:    r = 33'd4294967296;
            4'd2:    r = 33'd2147483648;
            4'd3:    r = 33'd1431655765;
            4'd4:    r = 33'd1073741824;
            4'd5:    r = 33'd858993459;
            4'd6:    r = 33'd715827882;
            4'd7:    r = 33'd613566756;
            4'd8:    r = 33'd536870912;
            4'd9:    r = 33'd477218588;
            4'd10:   r = 33'd429496729;
            4'd11:   r = 33'd390451572;
            4'd12:   r = 33'd357913941;
            default: r = 33'd0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/monte_carlo_option_payoff_accumulator.sv */
// ----------------------------------------------------------------------------
// Monte Carlo option payoff accumulator
// Prices European call and put options from a stream of normal samples.
// ----------------------------------------------------------------------------
// Each sample z prices one path, or two with the mirrored path -z when
// antithetic mode is on. Each path runs a two-step range reduction of the
// exponent by ln(2) through a reciprocal multiply with one correction, and a
// 12-term Taylor series of exp(f). A sample marked last then starts the
// bit-serial division of each sum by the path count and the discounting,
// after which the prices and path count appear on the output stream and the
// sums clear. A four-entry queue buffers samples ahead of the pricing
// sequencer, and a finished result waits in its own output register.
module monte_carlo_option_payoff_accumulator #(
    parameter int SUM_WIDTH   = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // Sample stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] normal_sample
    input  logic        s_tlast,   // last_sample
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [31:0] call premium, [63:32] put premium,
                                   // [95:64] paths_used
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0]        spot_reg;
    logic [31:0]        strike_reg;
    logic signed [31:0] drift_reg;
    logic [30:0]        diffusion_reg;
    logic [31:0]        discount_reg;
    logic               anti_reg;
    logic               cfg_write;
    logic [2:0]         reg_index;

    mcopa_pkg::price_cfg_t    cfg;
    mcopa_pkg::queue_entry_t  push_entry;
    mcopa_pkg::queue_entry_t  head;
    mcopa_pkg::queue_status_t qstat;
    logic                     push;
    logic                     pop;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spot_reg      <= 32'd6553600;
            strike_reg    <= 32'd6553600;
            drift_reg     <= '0;
            diffusion_reg <= '0;
            discount_reg  <= 32'hFFFF_FFFF;
            anti_reg      <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                mcopa_pkg::REG_SPOT:     spot_reg      <= pwdata;
                mcopa_pkg::REG_STRIKE:   strike_reg    <= pwdata;
                mcopa_pkg::REG_DRIFT:    drift_reg     <= $signed(pwdata);
                mcopa_pkg::REG_DIFFUSE:  diffusion_reg <= pwdata[30:0];
                mcopa_pkg::REG_DISCOUNT: discount_reg  <= pwdata;
                mcopa_pkg::REG_ANTI:     anti_reg      <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (reg_index)
            mcopa_pkg::REG_SPOT:     prdata = spot_reg;
            mcopa_pkg::REG_STRIKE:   prdata = strike_reg;
            mcopa_pkg::REG_DRIFT:    prdata = drift_reg;
            mcopa_pkg::REG_DIFFUSE:  prdata = {1'b0, diffusion_reg};
            mcopa_pkg::REG_DISCOUNT: prdata = discount_reg;
            mcopa_pkg::REG_ANTI:     prdata = {31'd0, anti_reg};
            default:                 prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.spot      = spot_reg;
        cfg.strike    = strike_reg;
        cfg.drift     = drift_reg;
        cfg.diffusion = diffusion_reg;
        cfg.discount  = discount_reg;
    end

    mcopa_front u_front (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .anti_enable (anti_reg),
        .qstat       (qstat),
        .push        (push),
        .push_entry  (push_entry)
    );

    mcopa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    mcopa_engine #(
        .SUM_WIDTH   (SUM_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .head     (head),
        .qstat    (qstat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* rtl/core/mcopa_front.sv */
// ----------------------------------------------------------------------------
// Monte Carlo option payoff accumulator front
// Accepts samples from the input stream and tags each one with the
// antithetic mode in force, then pushes it into the queue.
// ----------------------------------------------------------------------------
module mcopa_front (
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [15:0]             s_tdata,   // [15:0] normal_sample
    input  logic                    s_tlast,   // last_sample
    input  logic                    anti_enable,
    input  mcopa_pkg::queue_status_t qstat,
    output logic                    push,
    output mcopa_pkg::queue_entry_t push_entry
);

    // Take a transaction whenever the queue has room.
    assign s_tready = !qstat.full;
    assign push     = s_tvalid && !qstat.full;

    // Classify the sample: one path or a mirrored pair, and end of batch.
    always_comb
    begin
        push_entry.z    = $signed(s_tdata);
        push_entry.last = s_tlast;
        push_entry.anti = anti_enable;
    end

endmodule

/* rtl/core/mcopa_queue.sv */
// ----------------------------------------------------------------------------
// Monte Carlo option payoff accumulator queue
// Short first-in first-out queue that lets the front and the back stall
// independently.
// ----------------------------------------------------------------------------
module mcopa_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  mcopa_pkg::queue_entry_t  push_entry,
    input  logic                     pop,
    output mcopa_pkg::queue_entry_t  head,
    output mcopa_pkg::queue_status_t qstat
);

    localparam int PW = $clog2(mcopa_pkg::QUEUE_DEPTH);

    mcopa_pkg::queue_entry_t entry_reg [mcopa_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   fill_reg, fill_next;

    assign head        = entry_reg[rd_ptr_reg];
    assign qstat.full  = (fill_reg == (PW+1)'(mcopa_pkg::QUEUE_DEPTH));
    assign qstat.empty = (fill_reg == '0);

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage carries no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* rtl/core/mcopa_div.sv */
// ----------------------------------------------------------------------------
// Monte Carlo option payoff accumulator divider
// Restoring divider that forms one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mcopa_div #(
    parameter int SUM_WIDTH   = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [SUM_WIDTH-1:0]   dividend,
    input  logic [COUNT_WIDTH-1:0] divisor,
    output logic                   done,
    output logic [SUM_WIDTH-1:0]   quotient
);

    localparam int CW = $clog2(SUM_WIDTH + 1);

    logic [SUM_WIDTH-1:0]   quo_reg, quo_next;
    logic [COUNT_WIDTH:0]   rem_reg, rem_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [COUNT_WIDTH:0]   rem_shift;
    logic                   fits;

    assign done     = done_reg;
    assign quotient = quo_reg;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb
    begin
        rem_shift = {rem_reg[COUNT_WIDTH-1:0], quo_reg[SUM_WIDTH-1]};
        fits      = (rem_shift >= {1'b0, divisor});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CW'(SUM_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[SUM_WIDTH-2:0], fits};
            rem_next = fits ? rem_shift - {1'b0, divisor} : rem_shift;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

endmodule

/* rtl/core/mcopa_engine.sv */
// ----------------------------------------------------------------------------
// Monte Carlo option payoff accumulator back end
// Sequencer that prices each path, accumulates the payoffs and, at the end
// of a batch, forms the discounted means in an output register.
// ----------------------------------------------------------------------------
module mcopa_engine #(
    parameter int SUM_WIDTH   = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mcopa_pkg::price_cfg_t    cfg,
    input  mcopa_pkg::queue_entry_t  head,
    input  mcopa_pkg::queue_status_t qstat,
    output logic                     pop,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [95:0]              m_tdata
);

    mcopa_pkg::eng_state_t state_reg, state_next;

    logic signed [15:0]    z_reg, z_next;
    logic                  last_reg, last_next;
    logic                  anti_reg, anti_next;
    logic                  path_reg, path_next;
    logic signed [48:0]    prod_reg, prod_next;
    logic [36:0]           rem_reg, rem_next;
    logic [7:0]            q_reg, q_next;
    logic                  kphase_reg, kphase_next;
    logic [28:0]           term_reg, term_next;
    logic [29:0]           esum_reg, esum_next;
    logic [3:0]            n_reg, n_next;
    logic [56:0]           tp_reg, tp_next;
    logic [61:0]           m_reg, m_next;
    logic [61:0]           ps_reg, ps_next;
    logic [31:0]           st_reg, st_next;
    logic [SUM_WIDTH-1:0]  call_sum_reg, call_sum_next;
    logic [SUM_WIDTH-1:0]  put_sum_reg, put_sum_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                  sel_reg, sel_next;
    logic [31:0]           plo_reg, plo_next;
    logic [63:0]           phi_reg, phi_next;
    logic [31:0]           cprice_reg, cprice_next;
    logic [31:0]           pprice_reg, pprice_next;
    logic                  out_valid_reg, out_valid_next;
    logic [31:0]           out_call_reg, out_call_next;
    logic [31:0]           out_put_reg, out_put_next;
    logic [31:0]           out_paths_reg, out_paths_next;

    // Combinational helpers.
    logic signed [16:0]    zx, zsel;
    logic signed [37:0]    xsum;
    logic [56:0]           kprod;
    logic [36:0]           kmul;
    logic [36:0]           kdiff;
    logic                  kfit;
    logic [28:0]           tq;
    logic [28:0]           q0;
    logic [32:0]           tr;
    logic                  tcor;
    logic signed [8:0]     kval;
    logic [7:0]            shamt;
    logic [61:0]           shr;
    logic [31:0]           lim;
    logic [61:0]           shl;
    logic [31:0]           st_val;
    logic [31:0]           call_pay, put_pay;
    logic [SUM_WIDTH:0]    call_add, put_add;
    logic                  more_path;
    logic                  div_start;
    logic                  div_done, div_done_put;
    logic [SUM_WIDTH-1:0]  call_mean, put_mean;
    logic [SUM_WIDTH-1:0]  mean_sel;
    logic [31:0]           mul_a;
    logic [64:0]           pv;
    logic [31:0]           price;
    logic                  out_load;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_paths_reg, out_put_reg, out_call_reg};

    assign more_path = !path_reg && anti_reg;
    assign out_load  = (state_reg == mcopa_pkg::ST_OUT) && (!out_valid_reg || m_tready);

    // Mean of each sum over the path count.
    mcopa_div #(
        .SUM_WIDTH   (SUM_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_div_call (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (call_sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (call_mean)
    );

    mcopa_div #(
        .SUM_WIDTH   (SUM_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_div_put (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (put_sum_reg),
        .divisor  (count_reg),
        .done     (div_done_put),
        .quotient (put_mean)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mcopa_pkg::ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    state_next = mcopa_pkg::ST_MULX;
                end
            end
            mcopa_pkg::ST_MULX:  state_next = mcopa_pkg::ST_XSUM;
            mcopa_pkg::ST_XSUM:  state_next = mcopa_pkg::ST_KDIV;
            mcopa_pkg::ST_KDIV:
            begin
                if (!kphase_reg)
                begin
                    state_next = mcopa_pkg::ST_TMUL;
                end
            end
            mcopa_pkg::ST_TMUL:  state_next = mcopa_pkg::ST_TREC;
            mcopa_pkg::ST_TREC:  state_next = mcopa_pkg::ST_TCOR;
            mcopa_pkg::ST_TCOR:
            begin
                state_next = (n_reg == mcopa_pkg::EXP_TERMS) ? mcopa_pkg::ST_SPOT
                                                             : mcopa_pkg::ST_TMUL;
            end
            mcopa_pkg::ST_SPOT:  state_next = mcopa_pkg::ST_SHIFT;
            mcopa_pkg::ST_SHIFT: state_next = mcopa_pkg::ST_ACC;
            mcopa_pkg::ST_ACC:
            begin
                priority if (more_path)
                begin
                    state_next = mcopa_pkg::ST_MULX;
                end
                else if (last_reg)
                begin
                    state_next = mcopa_pkg::ST_DIVGO;
                end
                else
                begin
                    state_next = mcopa_pkg::ST_IDLE;
                end
            end
            mcopa_pkg::ST_DIVGO: state_next = mcopa_pkg::ST_DIV;
            mcopa_pkg::ST_DIV:
            begin
                if (div_done && div_done_put)
                begin
                    state_next = mcopa_pkg::ST_MLO;
                end
            end
            mcopa_pkg::ST_MLO:   state_next = mcopa_pkg::ST_MHI;
            mcopa_pkg::ST_MHI:   state_next = mcopa_pkg::ST_MADD;
            mcopa_pkg::ST_MADD:
            begin
                state_next = sel_reg ? mcopa_pkg::ST_OUT : mcopa_pkg::ST_MLO;
            end
            mcopa_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = mcopa_pkg::ST_IDLE;
                end
            end
            default:             state_next = mcopa_pkg::ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        pop       = (state_reg == mcopa_pkg::ST_IDLE) && !qstat.empty;
        div_start = (state_reg == mcopa_pkg::ST_DIVGO);
    end

    // Datapath arithmetic shared by the steps below.
    always_comb
    begin
        // Exponent of the current path.
        zx     = 17'(z_reg);
        zsel   = path_reg ? -zx : zx;
        xsum   = 38'(cfg.drift) + 38'(prod_reg >>> 12) + $signed(mcopa_pkg::X_OFFSET);
        // Range reduction by ln(2): a reciprocal estimate that is at most one
        // short, then one compare and subtract.
        kprod  = 57'(rem_reg[35:0]) * 57'(mcopa_pkg::LN2_RECIP);
        kmul   = 37'(q_reg) * mcopa_pkg::LN2_Q28;
        kdiff  = rem_reg - kmul;
        kfit   = (kdiff >= mcopa_pkg::LN2_Q28);
        // Taylor term divided by n through its reciprocal and one correction.
        tq     = tp_reg[56:28];
        q0     = m_reg[60:32];
        tr     = 33'(tq) - 33'(q0) * 33'(n_reg);
        tcor   = (tr >= 33'(n_reg));
        // Scale by 2^k and saturate to 32 bits.
        kval   = $signed({1'b0, q_reg}) - mcopa_pkg::K_BIAS;
        shr    = '0;
        shl    = '0;
        lim    = '0;
        shamt  = '0;
        if (kval <= 9'sd28)
        begin
            shamt = 8'(9'sd28 - kval);
            shr   = (shamt >= 8'd64) ? 62'd0 : ps_reg >> shamt[5:0];
            st_val = (shr[61:32] != '0) ? mcopa_pkg::MAX32 : shr[31:0];
        end
        else
        begin
            shamt = 8'(kval - 9'sd28);
            lim   = mcopa_pkg::MAX32 >> shamt[4:0];
            shl   = ps_reg << shamt[4:0];
            priority if (ps_reg == '0)
            begin
                st_val = '0;
            end
            else if (shamt >= 8'd32)
            begin
                st_val = mcopa_pkg::MAX32;
            end
            else if (ps_reg > 62'(lim))
            begin
                st_val = mcopa_pkg::MAX32;
            end
            else
            begin
                st_val = shl[31:0];
            end
        end
        // Payoffs and saturating sums.
        call_pay = (st_reg > cfg.strike) ? st_reg - cfg.strike : '0;
        put_pay  = (cfg.strike > st_reg) ? cfg.strike - st_reg : '0;
        call_add = {1'b0, call_sum_reg} + (SUM_WIDTH+1)'(call_pay);
        put_add  = {1'b0, put_sum_reg} + (SUM_WIDTH+1)'(put_pay);
        // Discounting: low and high halves of the mean on one multiplier.
        mean_sel = sel_reg ? put_mean : call_mean;
        mul_a    = (state_reg == mcopa_pkg::ST_MHI) ? 32'(mean_sel[SUM_WIDTH-1:32])
                                                    : mean_sel[31:0];
        pv       = 65'(phi_reg) + 65'(plo_reg);
        price    = (pv[64:32] != '0) ? mcopa_pkg::MAX32 : pv[31:0];
    end

    // Register updates of each step.
    always_comb
    begin
        z_next         = z_reg;
        last_next      = last_reg;
        anti_next      = anti_reg;
        path_next      = path_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        kphase_next    = kphase_reg;
        term_next      = term_reg;
        esum_next      = esum_reg;
        n_next         = n_reg;
        tp_next        = tp_reg;
        m_next         = m_reg;
        ps_next        = ps_reg;
        st_next        = st_reg;
        call_sum_next  = call_sum_reg;
        put_sum_next   = put_sum_reg;
        count_next     = count_reg;
        sel_next       = sel_reg;
        plo_next       = plo_reg;
        phi_next       = phi_reg;
        cprice_next    = cprice_reg;
        pprice_next    = pprice_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_call_next  = out_call_reg;
        out_put_next   = out_put_reg;
        out_paths_next = out_paths_reg;
        unique case (state_reg)
            mcopa_pkg::ST_IDLE:
            begin
                z_next    = head.z;
                last_next = head.last;
                anti_next = head.anti;
                path_next = 1'b0;
            end
            mcopa_pkg::ST_MULX:
            begin
                prod_next = $signed({1'b0, cfg.diffusion}) * zsel;
            end
            mcopa_pkg::ST_XSUM:
            begin
                rem_next    = {1'b0, xsum[35:0]};
                q_next      = '0;
                kphase_next = 1'b1;
            end
            mcopa_pkg::ST_KDIV:
            begin
                if (kphase_reg)
                begin
                    q_next = kprod[55:48];
                end
                else
                begin
                    rem_next = kfit ? kdiff - mcopa_pkg::LN2_Q28 : kdiff;
                    q_next   = q_reg + 8'(kfit);
                end
                kphase_next = 1'b0;
                term_next   = 29'd1 << mcopa_pkg::FRAC_BITS;
                esum_next   = 30'd1 << mcopa_pkg::FRAC_BITS;
                n_next      = 4'd1;
            end
            mcopa_pkg::ST_TMUL:
            begin
                tp_next = term_reg * rem_reg[27:0];
            end
            mcopa_pkg::ST_TREC:
            begin
                m_next = tq * mcopa_pkg::recip(n_reg);
            end
            mcopa_pkg::ST_TCOR:
            begin
                term_next = q0 + 29'(tcor);
                esum_next = esum_reg + 30'(q0) + 30'(tcor);
                n_next    = n_reg + 1'b1;
            end
            mcopa_pkg::ST_SPOT:
            begin
                ps_next = cfg.spot * esum_reg;
            end
            mcopa_pkg::ST_SHIFT:
            begin
                st_next = st_val;
            end
            mcopa_pkg::ST_ACC:
            begin
                call_sum_next = call_add[SUM_WIDTH] ? '1 : call_add[SUM_WIDTH-1:0];
                put_sum_next  = put_add[SUM_WIDTH] ? '1 : put_add[SUM_WIDTH-1:0];
                if (count_reg != '1)
                begin
                    count_next = count_reg + 1'b1;
                end
                path_next = 1'b1;
                sel_next  = 1'b0;
            end
            mcopa_pkg::ST_DIVGO:
            begin
            end
            mcopa_pkg::ST_DIV:
            begin
            end
            mcopa_pkg::ST_MLO:
            begin
                plo_next = 32'((64'(mul_a) * 64'(cfg.discount)) >> 32);
            end
            mcopa_pkg::ST_MHI:
            begin
                phi_next = mul_a * cfg.discount;
            end
            mcopa_pkg::ST_MADD:
            begin
                if (sel_reg)
                begin
                    pprice_next = price;
                end
                else
                begin
                    cprice_next = price;
                end
                sel_next = 1'b1;
            end
            mcopa_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_call_next  = cprice_reg;
                    out_put_next   = pprice_reg;
                    out_paths_next = 32'(count_reg);
                    call_sum_next  = '0;
                    put_sum_next   = '0;
                    count_next     = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control and accumulator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mcopa_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            call_sum_reg  <= '0;
            put_sum_reg   <= '0;
            count_reg     <= '0;
            path_reg      <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            call_sum_reg  <= call_sum_next;
            put_sum_reg   <= put_sum_next;
            count_reg     <= count_next;
            path_reg      <= path_next;
            sel_reg       <= sel_next;
        end
    end

    // Working registers of the datapath.
    always_ff @(posedge clk)
    begin
        z_reg         <= z_next;
        last_reg      <= last_next;
        anti_reg      <= anti_next;
        prod_reg      <= prod_next;
        rem_reg       <= rem_next;
        q_reg         <= q_next;
        kphase_reg    <= kphase_next;
        term_reg      <= term_next;
        esum_reg      <= esum_next;
        n_reg         <= n_next;
        tp_reg        <= tp_next;
        m_reg         <= m_next;
        ps_reg        <= ps_next;
        st_reg        <= st_next;
        plo_reg       <= plo_next;
        phi_reg       <= phi_next;
        cprice_reg    <= cprice_next;
        pprice_reg    <= pprice_next;
        out_call_reg  <= out_call_next;
        out_put_reg   <= out_put_next;
        out_paths_reg <= out_paths_next;
    end

endmodule
